@@ src/stsum_pkg.sv @@
// ----------------------------------------------------------------------------
// stsum_pkg
// Shared constants and types for the segment tree range sum unit.
// ----------------------------------------------------------------------------
package stsum_pkg;

    localparam int LEAVES  = 1024;
    localparam int IDX_W   = 10;          // leaf index width, log2(LEAVES)
    localparam int NODE_W  = IDX_W + 1;   // node address width, 2*LEAVES nodes
    localparam int PTR_W   = NODE_W + 1;  // walk pointers reach 2*LEAVES
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 64;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic {
        REQ_SET = 1'b0,
        REQ_SUM = 1'b1
    } t_req;

    typedef struct packed {
        t_req               kind;
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic [SUM_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_back_status;

endpackage

@@ src/segment_tree_range_sum_unit.sv @@
// A set writes the leaf, then walks up reading each sibling and writing the parent;
// a sum walks the left and right bounds upward, then strobes o_valid, one node
// memory access per cycle. The engine takes a new item only once it is idle.
// A two-entry queue takes items while the engine works; busy is high when it is full.
// After reset the node memory is cleared with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// segment_tree_range_sum_unit
// Point-update, range-sum segment tree over 1024 leaves with 64-bit sums.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [stsum_pkg::IDX_W-1:0]   i_first_index,
    input  logic [stsum_pkg::IDX_W-1:0]   i_last_index,
    input  logic [stsum_pkg::VAL_W-1:0]   i_write_value,
    output logic                          o_valid,
    output logic [stsum_pkg::SUM_W-1:0]   o_range_sum
);
    import stsum_pkg::*;

    t_cmd         w_cmd;
    logic         w_cmd_valid;
    logic         w_pop;
    logic         w_push;
    t_q_status    w_q_status;
    t_back_status w_back_status;

    assign busy   = w_q_status.full || w_back_status.clearing;
    assign w_push = start && !busy;

    stsum_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_req_type    (i_req_type),
        .i_first_index (i_first_index),
        .i_last_index  (i_last_index),
        .i_write_value (i_write_value),
        .i_pop         (w_pop),
        .o_cmd         (w_cmd),
        .o_cmd_valid   (w_cmd_valid),
        .o_status      (w_q_status)
    );

    stsum_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_pop       (w_pop),
        .o_status    (w_back_status),
        .o_valid     (o_valid),
        .o_sum       (o_range_sum)
    );

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_status.clearing |-> !o_valid)
        else $error("result during memory clear");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (w_q_status.count != '0))
        else $error("accepted item missing from queue");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_back_status.idle && w_cmd_valid))
        else $error("dequeue while engine busy");
`endif

endmodule

@@ src/stsum_front.sv @@
// ----------------------------------------------------------------------------
// stsum_front
// Accepts items, decodes them into commands and queues them for the back end.
// ----------------------------------------------------------------------------
module stsum_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_req_type,
    input  logic [stsum_pkg::IDX_W-1:0]   i_first_index,
    input  logic [stsum_pkg::IDX_W-1:0]   i_last_index,
    input  logic [stsum_pkg::VAL_W-1:0]   i_write_value,
    input  logic                          i_pop,
    output stsum_pkg::t_cmd               o_cmd,
    output logic                          o_cmd_valid,
    output stsum_pkg::t_q_status          o_status
);
    import stsum_pkg::*;

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, n_wp;
    logic [Q_PTR_W-1:0] r_rp, n_rp;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    t_cmd               w_dec;
    logic               w_pop;

    always_comb begin
        w_dec.kind = t_req'(i_req_type);
        w_dec.lo   = i_first_index;
        w_dec.hi   = i_last_index;
        if (w_dec.kind == REQ_SET) begin
            w_dec.value = {{(SUM_W-VAL_W){i_write_value[VAL_W-1]}}, i_write_value};
        end else begin
            w_dec.value = '0;
        end
    end

    assign w_pop = i_pop && (r_cnt != '0);

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = w_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= w_dec;
        end
    end

    assign o_cmd          = r_q[r_rp];
    assign o_cmd_valid    = (r_cnt != '0);
    assign o_status.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_status.count = r_cnt;

endmodule

@@ src/stsum_back.sv @@
// ----------------------------------------------------------------------------
// stsum_back
// Tree engine: holds the node memory and walks it level by level for
// leaf updates and range sums; clears the memory after reset.
// ----------------------------------------------------------------------------
module stsum_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stsum_pkg::t_cmd               i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_pop,
    output stsum_pkg::t_back_status       o_status,
    output logic                          o_valid,
    output logic [stsum_pkg::SUM_W-1:0]   o_sum
);
    import stsum_pkg::*;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_LEAF = 8'b0000_0100,
        S_URD  = 8'b0000_1000,
        S_UWR  = 8'b0001_0000,
        S_SL   = 8'b0010_0000,
        S_SR   = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    logic [SUM_W-1:0]  r_mem [2*LEAVES];
    logic [SUM_W-1:0]  r_rdata;
    logic              mem_we;
    logic [NODE_W-1:0] mem_addr;
    logic [SUM_W-1:0]  mem_wdata;

    t_state            r_state, n_state;
    logic [NODE_W-1:0] r_clr, n_clr;
    logic [PTR_W-1:0]  r_l, n_l;
    logic [PTR_W-1:0]  r_r, n_r;
    logic [SUM_W-1:0]  r_cur, n_cur;
    logic [SUM_W-1:0]  r_acc, n_acc;
    logic              r_pend, n_pend;
    logic              r_valid, n_valid;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SUM_W-1:0]  w_upd;
    logic [SUM_W-1:0]  w_accsum;
    logic [PTR_W-1:0]  w_l_inc;

    assign w_upd    = r_cur + r_rdata;
    assign w_accsum = r_acc + (r_pend ? r_rdata : '0);
    assign w_l_inc  = r_l + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_l       = r_l;
        n_r       = r_r;
        n_cur     = r_cur;
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_valid   = 1'b0;
        n_sum     = r_sum;
        mem_we    = 1'b0;
        mem_addr  = r_l[NODE_W-1:0];
        mem_wdata = r_cur;
        o_pop     = 1'b0;
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    n_l   = {2'b01, i_cmd.lo};
                    n_r   = {2'b01, i_cmd.hi} + 1'b1;
                    n_cur = i_cmd.value;
                    n_acc  = '0;
                    n_pend = 1'b0;
                    n_state = (i_cmd.kind == REQ_SET) ? S_LEAF : S_SL;
                end
            end
            S_LEAF: begin
                mem_we  = 1'b1;
                n_state = S_URD;
            end
            S_URD: begin
                // read the sibling of the node just written
                mem_addr = r_l[NODE_W-1:0] ^ NODE_W'(1);
                if (r_l == PTR_W'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UWR;
                end
            end
            S_UWR: begin
                mem_we    = 1'b1;
                mem_addr  = r_l[NODE_W:1];
                mem_wdata = w_upd;
                n_cur     = w_upd;
                n_l       = r_l >> 1;
                n_state   = S_URD;
            end
            S_SL: begin
                n_acc  = w_accsum;
                n_pend = 1'b0;
                if (r_l < r_r) begin
                    if (r_l[0]) begin
                        n_pend = 1'b1;
                        n_l    = w_l_inc;
                    end
                    n_state = S_SR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SR: begin
                n_acc    = w_accsum;
                n_pend   = r_r[0];
                mem_addr = r_r[NODE_W-1:0] - 1'b1;
                n_l      = r_l >> 1;
                n_r      = r_r >> 1;
                n_state  = S_SL;
            end
            S_FIN: begin
                n_valid = 1'b1;
                n_sum   = r_acc;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l    <= n_l;
        r_r    <= n_r;
        r_cur  <= n_cur;
        r_acc  <= n_acc;
        r_pend <= n_pend;
        r_sum  <= n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    assign o_status.clearing = (r_state == S_CLR);
    assign o_status.idle     = (r_state == S_IDLE);
    assign o_valid           = r_valid;
    assign o_sum             = r_sum;

endmodule
